/* design/linear_interp_upsampler_unit_assert.svh */
// Assertion macros for the linear interpolation upsampler.
`ifndef LINEAR_INTERP_UPSAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_UPSAMPLER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define LIRP_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("lirp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LIRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lirp assertion failed");

`endif

/* design/lirp_pkg.sv */
// Types and constants shared by the linear interpolation upsampler modules.
package lirp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int STEP_BITS      = 16;
    localparam int MIN_STEP_SHIFT = 6;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd30106;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          sample_present;
    } lirp_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_of_run;
    } lirp_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_OUT
    } lirp_state_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic mul;
        logic out_valid;
        logic done;
    } lirp_ctrl_t;

endpackage

/* design/lirp_mul.sv */
// Shared multiplier: registered product of sample difference and phase.
module lirp_mul
    import lirp_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [SAMPLE_BITS:0]            diff,
    input  logic        [PHASE_BITS-1:0]           phase,
    output logic signed [SAMPLE_BITS+PHASE_BITS+1:0] prod
);

    logic signed [SAMPLE_BITS+PHASE_BITS+1:0] prod_reg;
    logic signed [PHASE_BITS:0]               phase_s;

    assign phase_s = $signed({1'b0, phase});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= diff * phase_s;
        end
    end

    assign prod = prod_reg;

endmodule

/* design/lirp_ctrl.sv */
// Sequencer: a multiply state and then an output state for each result.
module lirp_ctrl
    import lirp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       m_ready,
    input  logic       last,
    output lirp_ctrl_t ctrl
);

    lirp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = last ? ST_IDLE : ST_MUL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.ready = 1'b1;
                ctrl.load  = s_valid;
            end
            ST_MUL: begin
                ctrl.mul = 1'b1;
            end
            ST_OUT: begin
                ctrl.out_valid = 1'b1;
                ctrl.done      = m_ready && last;
            end
            default: ctrl = '0;
        endcase
    end

endmodule

/* design/linear_interp_upsampler_unit.sv */
// Linear interpolation upsampler: top level with sample and phase registers.
//
// Each accepted source sample (or starved marker, which repeats the held
// sample) yields one or more interpolated results, the last one flagged.
// Each result passes through the multiply state, on the shared multiplier, and
// then the output state, after the item has been accepted in the idle state;
// the output state holds while m_ready is low. The block takes no new item until
// the final result of the current one is transferred. phase_step may only be
// written while the block is idle; values below 2^(PHASE_BITS-6) are raised to
// that minimum, so an item yields at most 64 results.
module linear_interp_upsampler_unit
    import lirp_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [STEP_BITS-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lirp_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lirp_out_t            m_data
);

    `include "linear_interp_upsampler_unit_assert.svh"

    localparam logic [PHASE_BITS-1:0] MIN_STEP =
        PHASE_BITS'(1) << (PHASE_BITS - MIN_STEP_SHIFT);

    logic [STEP_BITS-1:0]          step_reg;
    logic signed [SAMPLE_BITS-1:0] held_reg, cur_reg;
    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic                          last_reg;

    logic [PHASE_BITS+STEP_BITS-1:0]           step_wide;
    logic [PHASE_BITS-1:0]                     step_bits, step_eff;
    logic [PHASE_BITS:0]                       phase_sum;
    logic signed [SAMPLE_BITS-1:0]             cur_in;
    logic signed [SAMPLE_BITS+PHASE_BITS+1:0]  prod;
    lirp_ctrl_t                                ctrl;

    // Only the low PHASE_BITS bits of the register count.
    assign step_wide = {{PHASE_BITS{1'b0}}, step_reg};
    assign step_bits = step_wide[PHASE_BITS-1:0];
    assign step_eff  = (step_bits < MIN_STEP) ? MIN_STEP : step_bits;
    // Carry out marks the phase reaching one; the low bits are then the new fraction.
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_eff};

    assign cur_in = s_data.sample_present ? s_data.sample_in : held_reg;

    lirp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .last    (last_reg),
        .ctrl    (ctrl)
    );

    lirp_mul #(
        .PHASE_BITS (PHASE_BITS)
    ) u_mul (
        .aclk  (aclk),
        .en    (ctrl.mul),
        .diff  (diff_reg),
        .phase (phase_reg),
        .prod  (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_RESET;
            held_reg  <= '0;
            phase_reg <= '0;
        end else begin
            if (cfg_wr_en) step_reg <= cfg_wr_data;
            if (ctrl.mul)  phase_reg <= phase_sum[PHASE_BITS-1:0];
            if (ctrl.done) held_reg <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cur_reg  <= cur_in;
            diff_reg <= {cur_in[SAMPLE_BITS-1], cur_in} - {held_reg[SAMPLE_BITS-1], held_reg};
        end
        if (ctrl.mul) begin
            last_reg <= phase_sum[PHASE_BITS];
        end
    end

    assign s_ready = ctrl.ready;
    assign m_valid = ctrl.out_valid;
    // Part-select of the product is the floored shift; result stays within the sample range.
    assign m_data.sample_out  = held_reg + prod[PHASE_BITS +: SAMPLE_BITS];
    assign m_data.last_of_run = last_reg;

    `LIRP_ASSERT_ALWAYS(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))
    `LIRP_ASSERT_NEXT(a_load_then_mul, aclk, aresetn, s_valid && s_ready, !m_valid && !s_ready)
    `LIRP_ASSERT_NEXT(a_last_frees_input, aclk, aresetn,
        m_valid && m_ready && m_data.last_of_run, s_ready)
    `LIRP_ASSERT_NEXT(a_more_results, aclk, aresetn,
        m_valid && m_ready && !m_data.last_of_run, !s_ready && !m_valid)

endmodule

/* sim/linear_interp_upsampler_unit_test.sv */
// Self-checking testbench for the linear interpolation upsampler unit.
module linear_interp_upsampler_unit_test
    import lirp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BITS  = 16;
    localparam int PHASE_ONE   = 1 << PHASE_BITS;
    localparam int MIN_STEP    = 1 << (PHASE_BITS - MIN_STEP_SHIFT);
    localparam int MAX_RUN     = 64;
    localparam int LONG_HOLD   = 250;
    localparam int QUIET_LIMIT = 3000;
    localparam int ITEMS_PER_SWEEP = 21;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pattern_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [STEP_BITS-1:0] cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    lirp_in_t             s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    lirp_out_t            m_data;

    // Predictor state
    logic signed [SAMPLE_BITS-1:0] last_src_sample = '0;
    logic [PHASE_BITS-1:0]         phase_acc       = '0;
    logic [STEP_BITS-1:0]          step_setting    = STEP_RESET;

    lirp_in_t  source_items[$];
    lirp_out_t due_outputs[$];

    int error_count = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int hold_left   = 0;
    int holds_asked = 0;
    int holds_taken = 0;
    int mode_left   = 0;
    int quiet_cycles = 0;
    rx_pattern_t rx_pattern = RX_FREE;

    linear_interp_upsampler_unit #(
        .PHASE_BITS(PHASE_BITS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Works out every interpolated output that one source transfer produces.
    function automatic void interpolate_source(lirp_in_t item);
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] cur;
        longint    diff;
        longint    term;
        int        phase;
        int        step;
        int        n;
        lirp_out_t res;
        prev = last_src_sample;
        cur  = item.sample_present ? item.sample_in : last_src_sample;
        diff = longint'(cur) - longint'(prev);
        step = int'(step_setting[PHASE_BITS-1:0]);
        if (step < MIN_STEP) begin
            step = MIN_STEP;
        end
        phase = int'(phase_acc);
        n = 0;
        while (phase < PHASE_ONE && n < MAX_RUN) begin
            // arithmetic shift of a signed product floors towards minus infinity
            term = (diff * longint'(phase)) >>> PHASE_BITS;
            res.sample_out  = SAMPLE_BITS'(longint'(prev) + term);
            res.last_of_run = (phase + step >= PHASE_ONE) || (n == MAX_RUN - 1);
            due_outputs.push_back(res);
            n++;
            phase += step;
        end
        phase_acc       = PHASE_BITS'(phase - PHASE_ONE);
        last_src_sample = cur;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                interpolate_source(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (source_items.size() != 0) begin
                    s_data  <= source_items.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall pattern, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            m_ready     <= 1'b0;
            hold_left   <= LONG_HOLD;
            holds_taken <= holds_taken + 1;
        end else begin
            if (mode_left == 0) begin
                rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 150);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_pattern)
                RX_FREE: begin
                    m_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= ~m_ready;
                end
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        lirp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output %0d",
                                          m_data.sample_out));
            end else begin
                want = due_outputs.pop_front();
                if (m_data.sample_out !== want.sample_out) begin
                    report_mismatch($sformatf("sample_out %0d, want %0d",
                                              m_data.sample_out, want.sample_out));
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              m_data.last_of_run, want.last_of_run));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_sample(logic signed [SAMPLE_BITS-1:0] value, logic present);
        lirp_in_t item;
        item.sample_in      = value;
        item.sample_present = present;
        source_items.push_back(item);
    endtask

    task automatic queue_random_sample();
        logic signed [SAMPLE_BITS-1:0] value;
        case ($urandom_range(0, 15))
            0:       value = 16'sh7FFF;
            1:       value = -16'sh8000;
            2:       value = '0;
            3:       value = -16'sd1;
            default: value = SAMPLE_BITS'($urandom);
        endcase
        queue_sample(value, $urandom_range(0, 4) != 0);
    endtask

    // Sampled at the falling edge so the sender's and checker's updates have settled.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (source_items.size() != 0 || s_valid || due_outputs.size() != 0);
    endtask

    task automatic write_step(logic [STEP_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        step_setting  = value;
    endtask

    initial begin : stimulus
        logic [STEP_BITS-1:0] sweep_steps[7];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Full-scale swings, small values and starved markers at the reset step
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(-16'sh8000, 1'b1);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample('0, 1'b1);
        queue_sample(-16'sd1, 1'b1);
        queue_sample(16'sd1, 1'b1);
        queue_sample(SAMPLE_BITS'($urandom), 1'b0);
        queue_sample(-16'sh8000, 1'b1);
        queue_sample(16'sh7FFF, 1'b0);
        wait_idle();

        // Zero step is raised to the minimum: longest runs
        write_step('0);
        queue_sample(-16'sh8000, 1'b1);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample('0, 1'b0);
        wait_idle();

        write_step(16'd1023);
        queue_sample(-16'sh8000, 1'b1);
        queue_sample(16'sh7FFF, 1'b1);
        wait_idle();

        // Largest step: one or two outputs per transfer
        write_step(16'hFFFF);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(-16'sh8000, 1'b1);
        queue_sample('0, 1'b1);
        queue_sample(-16'sh8000, 1'b0);
        queue_sample(-16'sd1, 1'b1);
        wait_idle();

        write_step(16'd1024);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(-16'sh8000, 1'b1);
        wait_idle();

        sweep_steps[0] = STEP_RESET;
        sweep_steps[1] = 16'hFFFF;
        sweep_steps[2] = STEP_BITS'($urandom_range(1024, 65535));
        sweep_steps[3] = STEP_BITS'($urandom_range(0, 1023));
        sweep_steps[4] = STEP_BITS'($urandom_range(20000, 65535));
        sweep_steps[5] = 16'd1024;
        sweep_steps[6] = STEP_BITS'($urandom_range(1024, 65535));
        for (int s = 0; s < 7; s++) begin
            write_step(sweep_steps[s]);
            // stall the output early on so the input backs up
            if (s == 0 || s == 4) begin
                holds_asked++;
            end
            for (int i = 0; i < ITEMS_PER_SWEEP; i++) begin
                queue_random_sample();
            end
            wait_idle();
        end

        repeat (2 * MAX_RUN + 8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
